// ===== hw/rtl/c2p_pkg.sv =====
package c2p_pkg;

	localparam int CORDIC_STEPS = 28;
	// CORDIC datapath: coordinates sit at 2^60 scale, gain and sqrt(2) need two more bits
	localparam int CORDIC_FRAC = 60;
	localparam int CORDIC_W = 62;
	localparam int Z_W = 32;
	localparam int MAG_W = 16;
	localparam int ANG_W = 16;
	localparam int OUT_TDATA_W = MAG_W + ANG_W;

	localparam logic [Z_W-1:0] ANG_HALF = 32'h8000_0000;
	localparam logic [Z_W-1:0] ANG_RND = 32'h0000_8000;
	localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5
	};

	typedef struct packed {
		logic signed [CORDIC_W-1:0] cx;
		logic signed [CORDIC_W-1:0] cy;
		logic [Z_W-1:0] z;
		logic org;
	} cordic_t;

endpackage

// ===== hw/rtl/c2p_cordic_cell.sv =====
module c2p_cordic_cell
	import c2p_pkg::*;
#(
	parameter int STEP = 0
) (
	input  logic    clk,
	input  logic    en,
	input  cordic_t d,
	output cordic_t q
);

	logic signed [CORDIC_W-1:0] dx;
	logic signed [CORDIC_W-1:0] dy;
	cordic_t nxt;

	always_comb begin
		dx = d.cx >>> STEP;
		dy = d.cy >>> STEP;
		nxt = d;
		// rotate toward the x axis by the sign of y
		if (d.cy[CORDIC_W-1]) begin
			nxt.cx = d.cx - dy;
			nxt.cy = d.cy + dx;
			nxt.z = d.z - ATAN_TAB[STEP];
		end else begin
			nxt.cx = d.cx + dy;
			nxt.cy = d.cy - dx;
			nxt.z = d.z + ATAN_TAB[STEP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// ===== hw/rtl/c2p_sqrt_cell.sv =====
module c2p_sqrt_cell
	import c2p_pkg::*;
#(
	parameter int SW = 32,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [SW-1:0] rem_d,
	input  logic [SW-1:0] res_d,
	output logic [SW-1:0] rem_q,
	output logic [SW-1:0] res_q
);

	localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * STEP);

	logic [SW-1:0] trial;
	logic [SW-1:0] rem_n;
	logic [SW-1:0] res_n;

	always_comb begin
		trial = res_d + BIT;
		if (rem_d >= trial) begin
			rem_n = rem_d - trial;
			res_n = (res_d >> 1) + BIT;
		end else begin
			rem_n = rem_d;
			res_n = res_d >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= rem_n;
			res_q <= res_n;
		end
	end

endmodule

// ===== hw/rtl/c2p_delay.sv =====
module c2p_delay
	import c2p_pkg::*;
#(
	parameter int W = 8,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

// ===== hw/rtl/cartesian_to_polar_core.sv =====
// channel   dir  tdata fields (lsb first)                     notes
// s_axis    in   x_coord [CW-1:0], y_coord [2CW-1:CW], pad    tready from skid state
// m_axis    out  magnitude [15:0], angle [31:16]              registered, skid behind it
//
// One word per cycle sustained while m_axis does not stall. The chain length is
// set by the 28 CORDIC micro-rotation cells or by the magnitude path (squares,
// sum, one root cell per bit), whichever is longer; the shorter one is padded.
// The whole chain moves on one enable; a one-word skid after the output register
// absorbs the word in flight, and s_axis_tready drops in the cycle after it fills.
// Reset clears the valid chain, the output register and the skid; data regs hold.
module cartesian_to_polar_core
	import c2p_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// x_coord, y_coord, zero pad to bytes
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,

	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// magnitude, angle
	output logic [OUT_TDATA_W-1:0]                   m_axis_tdata
);

	localparam int CW = COORD_WIDTH;
	localparam int SW = 2 * CW;             // width of x^2 + y^2
	localparam int PRESHIFT = CORDIC_FRAC - CW;
	localparam int MAG_LEN = CW + 2;        // squares, sum, one cell per root bit
	localparam int D = (MAG_LEN > CORDIC_STEPS) ? MAG_LEN : CORDIC_STEPS;
	localparam int MAG_PAD = D - MAG_LEN;
	localparam int COR_PAD = D - CORDIC_STEPS;

	// ---------------------------------------------------------------
	// Chain enable and valid tracking
	// ---------------------------------------------------------------
	logic       en;
	logic [D:0] vld_q;
	logic       push;
	logic       pop;
	logic       out_v_q;
	logic       sk_v_q;

	assign en = !sk_v_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[D-1:0], s_axis_tvalid};
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: unpack, absolute values, fold left half plane by pi
	// ---------------------------------------------------------------
	logic signed [CW-1:0] x_in;
	logic signed [CW-1:0] y_in;
	logic signed [CW:0]   xa;
	logic signed [CW:0]   ya;
	logic [CW-1:0]        ax;
	logic [CW-1:0]        ay;
	cordic_t              cor_in;

	assign x_in = s_axis_tdata[CW-1:0];
	assign y_in = s_axis_tdata[2*CW-1:CW];

	always_comb begin
		ax = x_in[CW-1] ? (~x_in + CW'(1)) : x_in;
		ay = y_in[CW-1] ? (~y_in + CW'(1)) : y_in;
		xa = x_in[CW-1] ? -(CW+1)'(x_in) : (CW+1)'(x_in);
		ya = x_in[CW-1] ? -(CW+1)'(y_in) : (CW+1)'(y_in);
		cor_in.cx = {xa[CW], xa, {PRESHIFT{1'b0}}};
		cor_in.cy = {ya[CW], ya, {PRESHIFT{1'b0}}};
		cor_in.z = x_in[CW-1] ? ANG_HALF : '0;
		cor_in.org = (x_in == '0) && (y_in == '0);
	end

	logic [CW-1:0] ax_s1;
	logic [CW-1:0] ay_s1;
	cordic_t       cor_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= ax;
			ay_s1 <= ay;
			cor_s1 <= cor_in;
		end
	end

	// ---------------------------------------------------------------
	// Magnitude: squares, sum, then one restoring root cell per bit
	// ---------------------------------------------------------------
	logic [SW-1:0] sqx_s2;
	logic [SW-1:0] sqy_s2;
	logic [SW-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= SW'(ax_s1) * SW'(ax_s1);
			sqy_s2 <= SW'(ay_s1) * SW'(ay_s1);
			sum_s3 <= sqx_s2 + sqy_s2;
		end
	end

	logic [SW-1:0] rem_c [CW+1];
	logic [SW-1:0] res_c [CW+1];

	assign rem_c[0] = sum_s3;
	assign res_c[0] = '0;

	for (genvar k = 0; k < CW; k++) begin : g_sqrt
		c2p_sqrt_cell #(
			.SW   (SW),
			.STEP (k)
		) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_d (rem_c[k]),
			.res_d (res_c[k]),
			.rem_q (rem_c[k+1]),
			.res_q (res_c[k+1])
		);
	end

	logic [SW-1:0] rem_f;
	logic [SW-1:0] res_f;

	if (MAG_PAD > 0) begin : g_mag_pad
		c2p_delay #(
			.W (2 * SW),
			.N (MAG_PAD)
		) u_pad (
			.clk (clk),
			.en  (en),
			.d   ({rem_c[CW], res_c[CW]}),
			.q   ({rem_f, res_f})
		);
	end else begin : g_mag_direct
		assign rem_f = rem_c[CW];
		assign res_f = res_c[CW];
	end

	// ---------------------------------------------------------------
	// Angle: CORDIC vectoring, one micro-rotation per cell
	// ---------------------------------------------------------------
	cordic_t cor_c [CORDIC_STEPS+1];
	cordic_t cor_f;

	assign cor_c[0] = cor_s1;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		c2p_cordic_cell #(
			.STEP (i)
		) u_cell (
			.clk (clk),
			.en  (en),
			.d   (cor_c[i]),
			.q   (cor_c[i+1])
		);
	end

	if (COR_PAD > 0) begin : g_cor_pad
		c2p_delay #(
			.W ($bits(cordic_t)),
			.N (COR_PAD)
		) u_pad (
			.clk (clk),
			.en  (en),
			.d   (cor_c[CORDIC_STEPS]),
			.q   (cor_f)
		);
	end else begin : g_cor_direct
		assign cor_f = cor_c[CORDIC_STEPS];
	end

	// ---------------------------------------------------------------
	// Rounding: root up when remainder exceeds it, angle to 16 bits
	// ---------------------------------------------------------------
	logic [SW-1:0]          mag_sum;
	logic [MAG_W-1:0]       mag;
	logic [Z_W-1:0]         z_rnd;
	logic [ANG_W-1:0]       ang;
	logic [OUT_TDATA_W-1:0] push_data;

	always_comb begin
		mag_sum = res_f + SW'(rem_f > res_f);
		if (mag_sum > SW'(MAG_MAX)) begin
			mag = MAG_MAX;
		end else begin
			mag = mag_sum[MAG_W-1:0];
		end
		z_rnd = cor_f.z + ANG_RND;
		ang = cor_f.org ? '0 : z_rnd[Z_W-1:Z_W-ANG_W];
		push_data = {ang, mag};
	end

	// ---------------------------------------------------------------
	// Output register plus one-word skid
	// ---------------------------------------------------------------
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic [OUT_TDATA_W-1:0] sk_data_q;

	assign push = en && vld_q[D];
	assign pop = out_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (sk_v_q) begin
			// chain frozen, drain skid first
			if (pop) begin
				sk_v_q <= 1'b0;
			end
		end else if (pop || !out_v_q) begin
			out_v_q <= push;
		end else if (push) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sk_v_q) begin
			if (pop) begin
				out_data_q <= sk_data_q;
			end
		end else if (pop || !out_v_q) begin
			out_data_q <= push_data;
		end else if (push) begin
			sk_data_q <= push_data;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_data_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> out_v_q)
		else $error("skid holds a word while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("skid filled without an output stall");

	a_origin_align: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (out_data_q[MAG_W-1:0] == '0)) |-> (out_data_q[OUT_TDATA_W-1:MAG_W] == '0))
		else $error("zero magnitude with nonzero angle: magnitude and angle chains out of step");

endmodule

// ===== tb/cartesian_to_polar_core_test.sv =====
`timescale 1ns / 100ps

module cartesian_to_polar_core_test;
	import c2p_pkg::*;

	localparam int COORD_W = 16;
	localparam int IN_TDATA_W = ((2*COORD_W+7)/8)*8;
	localparam int PRESHIFT = 60 - COORD_W;
	localparam int MICRO_ROTATIONS = 28;
	localparam int PHASE_ITEMS = 376;
	localparam int DRAIN_CYCLES = 40;	// waited after the last expected word, so stray extra words are caught
	localparam int N_CORNERS = 21;

	// laid out as on m_axis_tdata: angle in the upper half, magnitude in the lower
	typedef struct packed {
		logic signed [15:0] ang;
		logic [15:0] mag;
	} polar_t;

	// one directed point; known marks rows whose result is typed in here
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic known;
		logic [15:0] mag;
		logic signed [15:0] ang;
	} corner_t;

	// atan(2^-i), 2^32 = one full turn
	localparam logic [31:0] ARCTAN_STEP [MICRO_ROTATIONS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5
	};

	localparam corner_t CORNERS [N_CORNERS] = '{
		// origin gives zero angle
		'{16'sd0, 16'sd0, 1'b1, 16'd0, 16'sd0},
		// the four axes, unit length
		'{16'sd1, 16'sd0, 1'b1, 16'd1, 16'sd0},
		'{16'sd0, 16'sd1, 1'b1, 16'd1, 16'sd16384},
		'{-16'sd1, 16'sd0, 1'b1, 16'd1, 16'sh8000},	// +pi wraps to -pi
		'{16'sd0, -16'sd1, 1'b1, 16'd1, -16'sd16384},
		// the four axes at full scale
		'{16'sd32767, 16'sd0, 1'b1, 16'd32767, 16'sd0},
		'{16'sh8000, 16'sd0, 1'b1, 16'd32768, 16'sh8000},
		'{16'sd0, 16'sd32767, 1'b1, 16'd32767, 16'sd16384},
		'{16'sd0, 16'sh8000, 1'b1, 16'd32768, -16'sd16384},
		// corners of the square, largest magnitudes
		'{16'sd32767, 16'sd32767, 1'b0, 16'd0, 16'sd0},
		'{16'sh8000, 16'sh8000, 1'b0, 16'd0, 16'sd0},
		'{16'sh8000, 16'sd32767, 1'b0, 16'd0, 16'sd0},
		'{16'sd32767, 16'sh8000, 1'b0, 16'd0, 16'sd0},
		// just either side of the pi seam
		'{16'sh8000, 16'sd1, 1'b0, 16'd0, 16'sd0},
		'{16'sh8000, -16'sd1, 1'b0, 16'd0, 16'sd0},
		// small points, mostly in the left half plane
		'{-16'sd1, -16'sd1, 1'b0, 16'd0, 16'sd0},
		'{-16'sd1, 16'sd1, 1'b0, 16'd0, 16'sd0},
		'{16'sd3, 16'sd4, 1'b0, 16'd0, 16'sd0},
		'{-16'sd5, -16'sd12, 1'b0, 16'd0, 16'sd0},
		// alternating bit patterns
		'{16'sh5555, 16'shAAAA, 1'b0, 16'd0, 16'sd0},
		'{16'shAAAA, 16'sh5555, 1'b0, 16'd0, 16'sd0}
	};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;	// x_coord [15:0], y_coord [31:16]
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;	// magnitude [15:0], angle [31:16]

	polar_t polar_q [$];
	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;

	cartesian_to_polar_core #(
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Rounded integer sqrt for the magnitude, CORDIC vectoring for the angle.
	function automatic polar_t to_polar(logic signed [15:0] x, logic signed [15:0] y);
		longint sx;
		longint sy;
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		logic [63:0] cx;
		logic [63:0] cy;
		logic [63:0] dx;
		logic [63:0] dy;
		logic [31:0] z;
		polar_t p;
		sx = x;
		sy = y;
		rest = (sx < 0 ? -sx : sx) * (sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy) * (sy < 0 ? -sy : sy);
		root = 64'd0;
		probe = 64'd1 << 62;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 64'd0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		if (rest > root)
			root = root + 64'd1;
		p.mag = (root > 64'hFFFF) ? 16'hFFFF : root[15:0];

		if (sx == 0 && sy == 0) begin
			p.ang = 16'sd0;
			return p;
		end
		z = 32'd0;
		// left half plane: turn by pi first
		if (sx < 0) begin
			sx = -sx;
			sy = -sy;
			z = 32'h8000_0000;
		end
		cx = sx;
		cy = sy;
		cx = cx << PRESHIFT;
		cy = cy << PRESHIFT;
		for (int i = 0; i < MICRO_ROTATIONS; i++) begin
			dx = cx >> i;
			dy = $signed(cy) >>> i;
			if (cy[63]) begin
				cx = cx - dy;
				cy = cy + dx;
				z = z - ARCTAN_STEP[i];
			end else begin
				cx = cx + dy;
				cy = cy - dx;
				z = z + ARCTAN_STEP[i];
			end
		end
		z = z + 32'h0000_8000;
		p.ang = z[31:16];
		return p;
	endfunction

	function automatic logic signed [15:0] pick_coord();
		int unsigned kind;
		kind = $urandom_range(9);
		case (kind)
			6: return 16'(int'($urandom_range(40)) - 20);
			7: return $urandom_range(1) ? 16'sh8000 : 16'sd32767;
			8: return 16'sd0;
			9: return $urandom_range(1) ? 16'(16'sh8000 + $urandom_range(7))
				: 16'(16'sd32767 - $urandom_range(7));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic check_word(logic [OUT_TDATA_W-1:0] word);
		polar_t got;
		polar_t want;
		got = word;
		if (polar_q.size() == 0) begin
			report_mismatch("word with nothing pending, magnitude", int'(got.mag), 0);
			return;
		end
		want = polar_q.pop_front();
		if (got.mag !== want.mag)
			report_mismatch("magnitude", int'(got.mag), int'(want.mag));
		if (got.ang !== want.ang)
			report_mismatch("angle", int'(got.ang), int'(want.ang));
	endtask

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, polar_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		polar_q.push_back(want);
	endtask

	task automatic run_receiver();
		forever begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_word(m_axis_tdata);
		end
	endtask

	initial begin
		polar_t want;
		logic signed [15:0] x;
		logic signed [15:0] y;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		fork
			run_receiver();
		join_none

		// directed corners, back to back
		for (int r = 0; r < N_CORNERS; r++) begin
			if (CORNERS[r].known) begin
				want.mag = CORNERS[r].mag;
				want.ang = CORNERS[r].ang;
			end else begin
				want = to_polar(CORNERS[r].x, CORNERS[r].y);
			end
			send_point(CORNERS[r].x, CORNERS[r].y, want);
		end

		// random points: receiver-heavy stalls, then sender-heavy gaps, then none
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 68 : 0;
			recv_stall_pct = (phase == 0) ? 68 : (phase == 1) ? 32 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				x = pick_coord();
				y = pick_coord();
				send_point(x, y, to_polar(x, y));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (polar_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
